### rtl/assert_macros.svh
// Assertion macros used by the tracking band-pass top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset
`define AST_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under synchronous active-low reset
`define AST_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/pnco_pkg.sv
// Types, constants and the half-sine table of the tracking band-pass
`default_nettype none
package pnco_pkg;

    localparam int unsigned STATE_W = 5;

    localparam logic [STATE_W-1:0] ST_IDLE   = 5'd0;
    localparam logic [STATE_W-1:0] ST_MSTEP  = 5'd1;
    localparam logic [STATE_W-1:0] ST_PHASE  = 5'd2;
    localparam logic [STATE_W-1:0] ST_MINT   = 5'd3;
    localparam logic [STATE_W-1:0] ST_INTERP = 5'd4;
    localparam logic [STATE_W-1:0] ST_MNCO   = 5'd5;
    localparam logic [STATE_W-1:0] ST_NCO    = 5'd6;
    localparam logic [STATE_W-1:0] ST_MPD    = 5'd7;
    localparam logic [STATE_W-1:0] ST_PD     = 5'd8;
    localparam logic [STATE_W-1:0] ST_MLE1   = 5'd9;
    localparam logic [STATE_W-1:0] ST_MLE2   = 5'd10;
    localparam logic [STATE_W-1:0] ST_LE     = 5'd11;
    localparam logic [STATE_W-1:0] ST_MEC    = 5'd12;
    localparam logic [STATE_W-1:0] ST_EC     = 5'd13;
    localparam logic [STATE_W-1:0] ST_MDF1   = 5'd14;
    localparam logic [STATE_W-1:0] ST_MDF2   = 5'd15;
    localparam logic [STATE_W-1:0] ST_DF     = 5'd16;
    localparam logic [STATE_W-1:0] ST_MA1    = 5'd17;
    localparam logic [STATE_W-1:0] ST_A1     = 5'd18;
    localparam logic [STATE_W-1:0] ST_MB1    = 5'd19;
    localparam logic [STATE_W-1:0] ST_MB2    = 5'd20;
    localparam logic [STATE_W-1:0] ST_MB3    = 5'd21;
    localparam logic [STATE_W-1:0] ST_MB4    = 5'd22;
    localparam logic [STATE_W-1:0] ST_OUT    = 5'd23;

    // operand pair selects for the shared multiplier
    localparam logic [3:0] SRC_STEP = 4'd0;
    localparam logic [3:0] SRC_INT  = 4'd1;
    localparam logic [3:0] SRC_NCO  = 4'd2;
    localparam logic [3:0] SRC_PD   = 4'd3;
    localparam logic [3:0] SRC_LE1  = 4'd4;
    localparam logic [3:0] SRC_LE2  = 4'd5;
    localparam logic [3:0] SRC_EC   = 4'd6;
    localparam logic [3:0] SRC_DF1  = 4'd7;
    localparam logic [3:0] SRC_DF2  = 4'd8;
    localparam logic [3:0] SRC_A1   = 4'd9;
    localparam logic [3:0] SRC_B1   = 4'd10;
    localparam logic [3:0] SRC_B2   = 4'd11;
    localparam logic [3:0] SRC_B3   = 4'd12;
    localparam logic [3:0] SRC_B4   = 4'd13;

    localparam int unsigned OPW = 18;

    localparam logic signed [OPW-1:0] K_EC_SCALE = 18'sd24932;
    localparam logic signed [OPW-1:0] K_DEC_POLE = 18'sd29839;
    localparam logic signed [OPW-1:0] K_DEC_ZERO = 18'sd2928;
    localparam logic signed [OPW-1:0] K_BP_A1    = 18'sd30212;
    localparam logic signed [OPW-1:0] K_BP_A2    = 18'sd27986;
    localparam logic signed [OPW-1:0] K_BP_B0    = 18'sd2391;

    localparam logic [1:0] REG_AMP   = 2'd0;
    localparam logic [1:0] REG_GAIN  = 2'd1;
    localparam logic [1:0] REG_ALPHA = 2'd2;
    localparam logic [1:0] REG_STEP  = 2'd3;

    typedef struct packed {
        logic       mac_en;
        logic       clr;
        logic       neg;
        logic       shl;
        logic [3:0] src;
        logic       ld_phase;
        logic       ld_lo;
        logic       ld_interp;
        logic       ld_nco;
        logic       ld_pd;
        logic       ld_le;
        logic       ld_ec;
        logic       ld_df;
        logic       ld_a1;
        logic       ld_out;
    } ctl_t;

    function automatic logic [14:0] sine_lookup(input logic [5:0] idx);
        logic [14:0] v;
        case (idx)
            6'd0:  v = 15'd0;
            6'd1:  v = 15'd3212;
            6'd2:  v = 15'd6393;
            6'd3:  v = 15'd9512;
            6'd4:  v = 15'd12539;
            6'd5:  v = 15'd15446;
            6'd6:  v = 15'd18204;
            6'd7:  v = 15'd20787;
            6'd8:  v = 15'd23170;
            6'd9:  v = 15'd25329;
            6'd10: v = 15'd27245;
            6'd11: v = 15'd28898;
            6'd12: v = 15'd30273;
            6'd13: v = 15'd31356;
            6'd14: v = 15'd32137;
            6'd15: v = 15'd32609;
            6'd16: v = 15'd32767;
            6'd17: v = 15'd32609;
            6'd18: v = 15'd32137;
            6'd19: v = 15'd31356;
            6'd20: v = 15'd30273;
            6'd21: v = 15'd28898;
            6'd22: v = 15'd27245;
            6'd23: v = 15'd25329;
            6'd24: v = 15'd23170;
            6'd25: v = 15'd20787;
            6'd26: v = 15'd18204;
            6'd27: v = 15'd15446;
            6'd28: v = 15'd12539;
            6'd29: v = 15'd9512;
            6'd30: v = 15'd6393;
            6'd31: v = 15'd3212;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/pnco_mac.sv
// Shared multiply-accumulate unit with 32-bit wrapping accumulator
`default_nettype none
module pnco_mac (
    input  wire logic                               aclk,
    input  wire logic                               en,
    input  wire logic                               clr,
    input  wire logic                               neg,
    input  wire logic                               shl,
    input  wire logic signed [pnco_pkg::OPW-1:0]    op_a,
    input  wire logic signed [pnco_pkg::OPW-1:0]    op_b,
    output logic         [31:0]                     acc
);
    logic signed [2*pnco_pkg::OPW-1:0] prod;
    logic [31:0] term;
    logic [31:0] base;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;

    always_comb begin
        prod = op_a * op_b;
        term = shl ? {prod[30:0], 1'b0} : prod[31:0];
        if (neg) begin
            term = 32'd0 - term;
        end
        base = clr ? 32'd0 : acc_reg;
        acc_next = base + term;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;
endmodule
`default_nettype wire

### rtl/pnco_seq.sv
// Sequencer stepping one sample through the shared multiply-accumulate unit
`default_nettype none
module pnco_seq (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    input  wire logic                            out_free,
    output logic                                 in_ready,
    output pnco_pkg::ctl_t                       ctl
);
    logic [pnco_pkg::STATE_W-1:0] state_reg;
    logic [pnco_pkg::STATE_W-1:0] state_next;

    always_comb begin
        state_next = state_reg;
        ctl = '0;
        unique case (state_reg)
            pnco_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = pnco_pkg::ST_MSTEP;
                end
            end
            pnco_pkg::ST_MSTEP: begin
                ctl.mac_en = 1'b1; ctl.clr = 1'b1; ctl.src = pnco_pkg::SRC_STEP;
                state_next = pnco_pkg::ST_PHASE;
            end
            pnco_pkg::ST_PHASE: begin
                ctl.ld_phase = 1'b1;
                state_next = pnco_pkg::ST_MINT;
            end
            pnco_pkg::ST_MINT: begin
                ctl.mac_en = 1'b1; ctl.clr = 1'b1; ctl.src = pnco_pkg::SRC_INT;
                ctl.ld_lo = 1'b1;
                state_next = pnco_pkg::ST_INTERP;
            end
            pnco_pkg::ST_INTERP: begin
                ctl.ld_interp = 1'b1;
                state_next = pnco_pkg::ST_MNCO;
            end
            pnco_pkg::ST_MNCO: begin
                ctl.mac_en = 1'b1; ctl.clr = 1'b1; ctl.src = pnco_pkg::SRC_NCO;
                state_next = pnco_pkg::ST_NCO;
            end
            pnco_pkg::ST_NCO: begin
                ctl.ld_nco = 1'b1;
                state_next = pnco_pkg::ST_MPD;
            end
            pnco_pkg::ST_MPD: begin
                ctl.mac_en = 1'b1; ctl.clr = 1'b1; ctl.src = pnco_pkg::SRC_PD;
                state_next = pnco_pkg::ST_PD;
            end
            pnco_pkg::ST_PD: begin
                ctl.ld_pd = 1'b1;
                state_next = pnco_pkg::ST_MLE1;
            end
            pnco_pkg::ST_MLE1: begin
                ctl.mac_en = 1'b1; ctl.clr = 1'b1; ctl.src = pnco_pkg::SRC_LE1;
                state_next = pnco_pkg::ST_MLE2;
            end
            pnco_pkg::ST_MLE2: begin
                ctl.mac_en = 1'b1; ctl.src = pnco_pkg::SRC_LE2;
                state_next = pnco_pkg::ST_LE;
            end
            pnco_pkg::ST_LE: begin
                ctl.ld_le = 1'b1;
                state_next = pnco_pkg::ST_MEC;
            end
            pnco_pkg::ST_MEC: begin
                ctl.mac_en = 1'b1; ctl.clr = 1'b1; ctl.src = pnco_pkg::SRC_EC;
                state_next = pnco_pkg::ST_EC;
            end
            pnco_pkg::ST_EC: begin
                ctl.ld_ec = 1'b1;
                state_next = pnco_pkg::ST_MDF1;
            end
            pnco_pkg::ST_MDF1: begin
                ctl.mac_en = 1'b1; ctl.clr = 1'b1; ctl.src = pnco_pkg::SRC_DF1;
                state_next = pnco_pkg::ST_MDF2;
            end
            pnco_pkg::ST_MDF2: begin
                ctl.mac_en = 1'b1; ctl.src = pnco_pkg::SRC_DF2;
                state_next = pnco_pkg::ST_DF;
            end
            pnco_pkg::ST_DF: begin
                ctl.ld_df = 1'b1;
                state_next = pnco_pkg::ST_MA1;
            end
            pnco_pkg::ST_MA1: begin
                ctl.mac_en = 1'b1; ctl.clr = 1'b1; ctl.src = pnco_pkg::SRC_A1;
                state_next = pnco_pkg::ST_A1;
            end
            pnco_pkg::ST_A1: begin
                ctl.ld_a1 = 1'b1;
                state_next = pnco_pkg::ST_MB1;
            end
            pnco_pkg::ST_MB1: begin
                ctl.mac_en = 1'b1; ctl.clr = 1'b1; ctl.shl = 1'b1;
                ctl.src = pnco_pkg::SRC_B1;
                state_next = pnco_pkg::ST_MB2;
            end
            pnco_pkg::ST_MB2: begin
                ctl.mac_en = 1'b1; ctl.neg = 1'b1; ctl.src = pnco_pkg::SRC_B2;
                state_next = pnco_pkg::ST_MB3;
            end
            pnco_pkg::ST_MB3: begin
                ctl.mac_en = 1'b1; ctl.src = pnco_pkg::SRC_B3;
                state_next = pnco_pkg::ST_MB4;
            end
            pnco_pkg::ST_MB4: begin
                ctl.mac_en = 1'b1; ctl.neg = 1'b1; ctl.src = pnco_pkg::SRC_B4;
                state_next = pnco_pkg::ST_OUT;
            end
            pnco_pkg::ST_OUT: begin
                // hold until the output word slot is free
                if (out_free) begin
                    ctl.ld_out = 1'b1;
                    state_next = pnco_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pnco_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pnco_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == pnco_pkg::ST_IDLE);
endmodule
`default_nettype wire

### rtl/pll_nco_tracking_bandpass.sv
// The shared multiply-accumulate unit runs 14 products in sequence for each input word,
// interleaved with register loads; the sequencer then holds until the output slot is free
// and returns to idle, the only state that takes the next input word.
// A new input word is taken while the previous result still waits at the output register.
// Reset (aresetn, synchronous, active low) zeroes all filter state and reloads register defaults.
`default_nettype none
module pll_nco_tracking_bandpass #(
    parameter int unsigned DECIMATION = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_sample_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_nco_out,
    output logic signed [15:0]      m_band_out,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    `include "assert_macros.svh"

    localparam int unsigned OPW = pnco_pkg::OPW;

    pnco_pkg::ctl_t ctl;
    logic [31:0] acc;
    logic signed [OPW-1:0] op_a;
    logic signed [OPW-1:0] op_b;
    logic out_free;

    logic [14:0] amp_reg, gain_reg, alpha_reg, cstep_reg;
    logic signed [15:0] x_reg, phase_reg, lo_reg, interp_reg, nco_reg, pd_reg;
    logic signed [15:0] le_reg, ec_reg, df_reg, held_reg, a1_reg;
    logic signed [15:0] xi0_reg, xi1_reg, y0_reg, y1_reg;
    logic [5:0] dcnt_reg;
    logic [5:0] dcnt_next;
    logic m_valid_reg;
    logic signed [15:0] nco_out_reg, band_out_reg;

    logic [5:0] tab_idx;
    logic signed [16:0] lo_s, hi_s;
    logic signed [OPW-1:0] diff;
    logic [14:0] frac;
    logic [14:0] kf_tab;
    logic [14:0] kf_mag;
    logic signed [OPW-1:0] two_kf;
    logic signed [15:0] y_new;

    assign cfg_ready = 1'b1;
    assign out_free = !m_valid_reg || m_ready;

    pnco_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .out_free (out_free),
        .in_ready (s_ready),
        .ctl      (ctl)
    );

    pnco_mac u_mac (
        .aclk (aclk),
        .en   (ctl.mac_en),
        .clr  (ctl.clr),
        .neg  (ctl.neg),
        .shl  (ctl.shl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    // sine entries around the phase, sign-flipped in the lower half-turn
    always_comb begin
        tab_idx = {1'b0, phase_reg[14:10]};
        lo_s = 17'(signed'({2'b00, pnco_pkg::sine_lookup(tab_idx)}));
        hi_s = 17'(signed'({2'b00, pnco_pkg::sine_lookup(tab_idx + 6'd1)}));
        if (phase_reg[15]) begin
            lo_s = -lo_s;
            hi_s = -hi_s;
        end
        diff = OPW'(hi_s) - OPW'(lo_s);
        frac = {phase_reg[9:0], 5'b0};
        kf_tab = pnco_pkg::sine_lookup({1'b0, held_reg[15:11]});
        kf_mag = 15'((16'(kf_tab) + 16'd1) >> 1);
        two_kf = held_reg[15] ? OPW'({kf_mag, 1'b0}) : -OPW'({kf_mag, 1'b0});
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (ctl.src)
            pnco_pkg::SRC_STEP: begin op_a = OPW'(gain_reg);  op_b = OPW'(le_reg); end
            pnco_pkg::SRC_INT:  begin op_a = diff;            op_b = OPW'(frac); end
            pnco_pkg::SRC_NCO:  begin op_a = OPW'(amp_reg);   op_b = OPW'(interp_reg); end
            pnco_pkg::SRC_PD:   begin op_a = OPW'(x_reg);     op_b = OPW'(nco_reg); end
            pnco_pkg::SRC_LE1:  begin op_a = OPW'(alpha_reg); op_b = OPW'(le_reg); end
            pnco_pkg::SRC_LE2:  begin op_a = {3'b000, ~alpha_reg}; op_b = OPW'(pd_reg); end
            pnco_pkg::SRC_EC:   begin op_a = OPW'(le_reg);    op_b = pnco_pkg::K_EC_SCALE; end
            pnco_pkg::SRC_DF1:  begin op_a = pnco_pkg::K_DEC_POLE; op_b = OPW'(df_reg); end
            pnco_pkg::SRC_DF2:  begin op_a = pnco_pkg::K_DEC_ZERO; op_b = OPW'(ec_reg); end
            pnco_pkg::SRC_A1:   begin op_a = two_kf;          op_b = pnco_pkg::K_BP_A1; end
            pnco_pkg::SRC_B1:   begin op_a = OPW'(a1_reg);    op_b = OPW'(y0_reg); end
            pnco_pkg::SRC_B2:   begin op_a = pnco_pkg::K_BP_A2; op_b = OPW'(y1_reg); end
            pnco_pkg::SRC_B3:   begin op_a = pnco_pkg::K_BP_B0; op_b = OPW'(x_reg); end
            pnco_pkg::SRC_B4:   begin op_a = pnco_pkg::K_BP_B0; op_b = OPW'(xi1_reg); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign y_new = acc[30:15];

    always_comb begin
        dcnt_next = dcnt_reg + 6'd1;
        if (dcnt_next == 6'(DECIMATION)) begin
            dcnt_next = 6'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_reg <= 15'd32767;
            gain_reg <= 15'd27853;
            alpha_reg <= 15'd31523;
            cstep_reg <= 15'd16384;
            phase_reg <= '0;
            le_reg <= '0;
            df_reg <= '0;
            held_reg <= '0;
            dcnt_reg <= '0;
            xi0_reg <= '0;
            xi1_reg <= '0;
            y0_reg <= '0;
            y1_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready && cfg_index[7:2] == 6'd0) begin
                unique case (cfg_index[1:0])
                    pnco_pkg::REG_AMP:   amp_reg <= cfg_data[14:0];
                    pnco_pkg::REG_GAIN:  gain_reg <= cfg_data[14:0];
                    pnco_pkg::REG_ALPHA: alpha_reg <= cfg_data[14:0];
                    pnco_pkg::REG_STEP:  cstep_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (ctl.ld_phase) begin
                phase_reg <= phase_reg + 16'(cstep_reg) + acc[30:15];
            end
            if (ctl.ld_le) begin
                le_reg <= acc[30:15];
            end
            if (ctl.ld_df) begin
                df_reg <= acc[30:15];
                dcnt_reg <= dcnt_next;
                if (dcnt_next == 6'd0 && (dcnt_reg + 6'd1) == 6'(DECIMATION)) begin
                    held_reg <= acc[30:15];
                end
            end
            if (ctl.ld_out) begin
                y1_reg <= y0_reg;
                y0_reg <= y_new;
                xi1_reg <= xi0_reg;
                xi0_reg <= x_reg;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg <= s_sample_in;
        end
        if (ctl.ld_lo) begin
            lo_reg <= lo_s[15:0];
        end
        if (ctl.ld_interp) begin
            interp_reg <= lo_reg + acc[30:15];
        end
        if (ctl.ld_nco) begin
            nco_reg <= acc[30:15];
        end
        if (ctl.ld_pd) begin
            pd_reg <= acc[30:15];
        end
        if (ctl.ld_ec) begin
            ec_reg <= acc[29:14];
        end
        if (ctl.ld_a1) begin
            a1_reg <= acc[30:15];
        end
        if (ctl.ld_out) begin
            nco_out_reg <= nco_reg;
            band_out_reg <= y_new;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_nco_out = nco_out_reg;
    assign m_band_out = band_out_reg;

    `AST_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `AST_SAME(a_out_load_free, aclk, aresetn, ctl.ld_out, !m_valid_reg || m_ready)
    `AST_SAME(a_dcnt_below, aclk, aresetn, 1'b1, dcnt_reg != 6'(DECIMATION))
    `AST_SAME(a_mac_idle, aclk, aresetn, s_ready, !ctl.mac_en)
endmodule
`default_nettype wire
